// ===== rtl/ptw_pkg.sv =====
// Shared constants, types and helper functions of the page table walker.
`default_nettype none

package ptw_pkg;

  localparam int unsigned LEVELS     = 5;
  localparam int unsigned INDEX_BITS = 9;
  localparam int unsigned FRAMES     = 64;
  localparam int unsigned PAGE_BITS  = 52;

  localparam int unsigned VPN_W    = 45;
  localparam int unsigned FRAME_W  = $clog2(FRAMES);
  localparam int unsigned ADDR_W   = FRAME_W + INDEX_BITS;
  localparam int unsigned DEPTH    = FRAMES << INDEX_BITS;
  localparam int unsigned ENTRY_W  = PAGE_BITS + 1;
  localparam int unsigned LVL_W    = $clog2(LEVELS);
  localparam int unsigned NEXT_W   = 7;
  localparam int unsigned ROOT_W   = 6;
  localparam int unsigned CFG_W    = 7;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_UNMAPPED = 2'd1,
    STAT_NO_FRAME = 2'd2
  } status_e;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } command_e;

  typedef enum logic {
    CFG_ROOT_FRAME = 1'b0,
    CFG_FIRST_FREE = 1'b1
  } cfg_index_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_WIPE,
    ST_LINK
  } state_e;

  // Table index used at a given level; the top level takes the top slice.
  function automatic logic [INDEX_BITS-1:0] slice_of(input logic [VPN_W-1:0] vpn,
                                                     input logic [LVL_W-1:0] lvl);
    logic [INDEX_BITS-1:0] s;
    s = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (lvl == LVL_W'(l)) begin
        s = vpn[INDEX_BITS*(LEVELS-1-l) +: INDEX_BITS];
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/five_level_page_table_walker.sv =====
// Five-level page table walker with an internal frame store and bump allocator.
// A walk reads and then evaluates each level that it visits; the result shows on
// done_o, and the next start can be taken in the same cycle that done_o is high.
// Each frame allocated on a map is first cleared entry by entry and then linked.
// After reset the store is cleared with busy high; results cannot be stalled.
`default_nettype none

module five_level_page_table_walker import ptw_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Command side.
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  command_i,
  input  wire logic [VPN_W-1:0]      virt_page_i,
  input  wire logic [PAGE_BITS-1:0]  phys_page_i,
  input  wire logic                  unmap_i,
  // Result side.
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [PAGE_BITS-1:0]       result_page_o,
  // Configuration write channel.
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic                  cfg_index_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i
);

  // Walk control.
  state_e                 state_q, state_d;
  logic [LVL_W-1:0]       level_q, level_d;
  logic [FRAME_W-1:0]     frame_q, frame_d;
  logic [ADDR_W-1:0]      cnt_q, cnt_d;
  logic [ADDR_W-1:0]      link_addr_q, link_addr_d;
  logic [NEXT_W-1:0]      next_frame_q, next_frame_d;
  logic [ROOT_W-1:0]      root_frame_q;

  // Latched item.
  logic                   cmd_q;
  logic [VPN_W-1:0]       vpn_q;
  logic [PAGE_BITS-1:0]   ppn_q;
  logic                   unmap_q;

  // Result registers.
  logic                   done_q, done_d;
  status_e                status_q, status_d;
  logic [PAGE_BITS-1:0]   page_q, page_d;

  // Table store port.
  logic                   mem_we, mem_re;
  logic [ADDR_W-1:0]      mem_addr;
  logic [ENTRY_W-1:0]     mem_wdata, mem_rdata;
  logic [ADDR_W-1:0]      walk_addr;
  logic                   accept;
  logic                   cfg_write;

  assign accept      = start && (state_q == ST_IDLE);
  assign busy        = (state_q != ST_IDLE);
  // Registers only change between items: never during the store clear, during a
  // walk, or at the edge that takes a new item.
  assign cfg_ready_o = (state_q == ST_IDLE) && !start;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign walk_addr   = {frame_q, slice_of(vpn_q, level_q)};

  ptw_ram #(
    .Depth (DEPTH),
    .Width (ENTRY_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Next state, store accesses and results.
  always_comb begin
    state_d      = state_q;
    level_d      = level_q;
    frame_d      = frame_q;
    cnt_d        = cnt_q;
    link_addr_d  = link_addr_q;
    next_frame_d = next_frame_q;
    done_d       = 1'b0;
    status_d     = status_q;
    page_d       = page_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = walk_addr;
    mem_wdata    = '0;

    unique case (state_q)
      ST_CLEAR: begin
        // Power-on sweep that marks every entry invalid.
        mem_we   = 1'b1;
        mem_addr = cnt_q;
        cnt_d    = cnt_q + ADDR_W'(1);
        if (cnt_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          level_d = '0;
          frame_d = root_frame_q[FRAME_W-1:0];
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        mem_re  = 1'b1;
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (level_q != LVL_W'(LEVELS - 1)) begin
          // Inner level: follow the link or decide how to handle a hole.
          if (mem_rdata[0]) begin
            frame_d = mem_rdata[FRAME_W:1];
            level_d = level_q + LVL_W'(1);
            state_d = ST_READ;
          end else if (cmd_q == CMD_QUERY) begin
            done_d   = 1'b1;
            status_d = STAT_UNMAPPED;
            page_d   = '0;
            state_d  = ST_IDLE;
          end else if (unmap_q) begin
            done_d   = 1'b1;
            status_d = STAT_OK;
            page_d   = '0;
            state_d  = ST_IDLE;
          end else if (next_frame_q >= NEXT_W'(FRAMES)) begin
            done_d   = 1'b1;
            status_d = STAT_NO_FRAME;
            page_d   = '0;
            state_d  = ST_IDLE;
          end else begin
            // Take a fresh frame; it is wiped before the link is written so that
            // a link landing inside the reused frame survives.
            link_addr_d  = walk_addr;
            frame_d      = next_frame_q[FRAME_W-1:0];
            next_frame_d = next_frame_q + NEXT_W'(1);
            cnt_d        = '0;
            state_d      = ST_WIPE;
          end
        end else begin
          // Leaf level.
          done_d  = 1'b1;
          page_d  = '0;
          state_d = ST_IDLE;
          status_d = STAT_OK;
          if (cmd_q == CMD_QUERY) begin
            if (mem_rdata[0]) begin
              page_d = mem_rdata[ENTRY_W-1:1];
            end else begin
              status_d = STAT_UNMAPPED;
            end
          end else begin
            mem_we    = 1'b1;
            mem_wdata = unmap_q ? '0 : {ppn_q, 1'b1};
          end
        end
      end
      ST_WIPE: begin
        mem_we   = 1'b1;
        mem_addr = {frame_q, cnt_q[INDEX_BITS-1:0]};
        cnt_d    = cnt_q + ADDR_W'(1);
        if (cnt_q[INDEX_BITS-1:0] == {INDEX_BITS{1'b1}}) begin
          state_d = ST_LINK;
        end
      end
      ST_LINK: begin
        mem_we    = 1'b1;
        mem_addr  = link_addr_q;
        mem_wdata = {{(ENTRY_W - FRAME_W - 1){1'b0}}, frame_q, 1'b1};
        level_d   = level_q + LVL_W'(1);
        state_d   = ST_READ;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A write of the allocator start restarts the allocator.
    if (cfg_write && (cfg_index_e'(cfg_index_i) == CFG_FIRST_FREE)) begin
      next_frame_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      level_q      <= '0;
      cnt_q        <= '0;
      next_frame_q <= NEXT_W'(1);
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      level_q      <= level_d;
      cnt_q        <= cnt_d;
      next_frame_q <= next_frame_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_frame_q <= '0;
    end else if (cfg_write && (cfg_index_e'(cfg_index_i) == CFG_ROOT_FRAME)) begin
      root_frame_q <= cfg_data_i[ROOT_W-1:0];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    frame_q     <= frame_d;
    link_addr_q <= link_addr_d;
    status_q    <= status_d;
    page_q      <= page_d;
    if (accept) begin
      cmd_q   <= command_i;
      vpn_q   <= virt_page_i;
      ppn_q   <= phys_page_i;
      unmap_q <= unmap_i;
    end
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign result_page_o = page_q;

endmodule

`default_nettype wire

// ===== rtl/ptw_ram.sv =====
// Single-port synchronous RAM with a registered read port.
`default_nettype none

module ptw_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sim/five_level_page_table_walker_tb.sv =====
// Self-checking testbench for the five-level page table walker: directed table, then random walks.
module five_level_page_table_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptw_pkg::*;

  localparam int unsigned ENTRIES      = 1 << INDEX_BITS;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 172;
  // The store clear after reset runs without any handshake.
  localparam int unsigned IDLE_LIMIT   = 150000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned KNOWN_DEPTH  = 24;

  localparam logic [VPN_W-1:0]     VPN_MAX  = '1;
  localparam logic [PAGE_BITS-1:0] PAGE_MAX = '1;
  localparam logic [PAGE_BITS-1:0] PAGE_A5  = 52'hA_5A5A_5A5A_5A5A;
  localparam logic [PAGE_BITS-1:0] PAGE_5A  = 52'h5_A5A5_A5A5_A5A5;
  // Top slice differs from every path built by the directed rows.
  localparam logic [VPN_W-1:0]     VPN_FAR  = 45'h1000_0000_0000;
  // Same upper path as page zero, but a new table one level above the leaf.
  localparam logic [VPN_W-1:0]     VPN_SIDE = 45'h0000_0000_0200;

  // What one walk reports back.
  typedef struct packed {
    status_e                status;
    logic [PAGE_BITS-1:0]   page;
  } walk_t;

  // One command item, optionally with a result that is known up front.
  typedef struct packed {
    command_e               cmd;
    logic [VPN_W-1:0]       vpn;
    logic [PAGE_BITS-1:0]   ppn;
    logic                   rm;
    logic                   has_exp;
    status_e                status;
    logic [PAGE_BITS-1:0]   page;
  } step_t;

  // Directed steps, run from the reset configuration: root table in frame 0 and
  // the allocator starting at frame 1. Rows with has_exp set carry their result;
  // the rest are checked against the walk predictor.
  localparam step_t DIRECTED_STEPS [20] = '{
    // Empty tables: every query misses at the top level.
    '{CMD_QUERY,  '0,       '0,       1'b0, 1'b1, STAT_UNMAPPED, '0},
    '{CMD_QUERY,  VPN_MAX,  '0,       1'b0, 1'b1, STAT_UNMAPPED, '0},
    // Map page zero to the largest physical page; builds four inner tables.
    '{CMD_UPDATE, '0,       PAGE_MAX, 1'b0, 1'b1, STAT_OK,       '0},
    '{CMD_QUERY,  '0,       '0,       1'b0, 1'b1, STAT_OK,       PAGE_MAX},
    // Largest virtual page to physical page zero on a separate path.
    '{CMD_UPDATE, VPN_MAX,  '0,       1'b0, 1'b1, STAT_OK,       '0},
    '{CMD_QUERY,  VPN_MAX,  PAGE_MAX, 1'b0, 1'b1, STAT_OK,       '0},
    // Shared path, empty leaf, then fill it without new tables.
    '{CMD_QUERY,  45'd1,    '0,       1'b0, 1'b1, STAT_UNMAPPED, '0},
    '{CMD_UPDATE, 45'd1,    PAGE_A5,  1'b0, 1'b1, STAT_OK,       '0},
    // A query ignores the physical page and the unmap flag.
    '{CMD_QUERY,  45'd1,    PAGE_MAX, 1'b1, 1'b0, STAT_OK,       '0},
    // Overwrite an existing leaf.
    '{CMD_UPDATE, '0,       PAGE_5A,  1'b0, 1'b0, STAT_OK,       '0},
    '{CMD_QUERY,  '0,       '0,       1'b0, 1'b0, STAT_OK,       '0},
    // Unmap on a path that does not exist writes nothing and still reports ok.
    '{CMD_UPDATE, VPN_FAR,  PAGE_MAX, 1'b1, 1'b1, STAT_OK,       '0},
    '{CMD_QUERY,  VPN_FAR,  '0,       1'b0, 1'b1, STAT_UNMAPPED, '0},
    // Unmap a live leaf, check it is gone, and unmap it a second time.
    '{CMD_UPDATE, '0,       '0,       1'b1, 1'b1, STAT_OK,       '0},
    '{CMD_QUERY,  '0,       '0,       1'b0, 1'b1, STAT_UNMAPPED, '0},
    '{CMD_UPDATE, '0,       PAGE_A5,  1'b1, 1'b1, STAT_OK,       '0},
    '{CMD_QUERY,  45'd1,    '0,       1'b0, 1'b0, STAT_OK,       '0},
    // One new table just above the leaf level.
    '{CMD_UPDATE, VPN_SIDE, 52'h1234, 1'b0, 1'b0, STAT_OK,       '0},
    '{CMD_QUERY,  VPN_SIDE, '0,       1'b0, 1'b0, STAT_OK,       '0},
    '{CMD_QUERY,  VPN_MAX,  PAGE_MAX, 1'b1, 1'b0, STAT_OK,       '0}
  };

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  command_e              command     = CMD_QUERY;
  logic [VPN_W-1:0]      virt_page   = '0;
  logic [PAGE_BITS-1:0]  phys_page   = '0;
  logic                  unmap       = 1'b0;
  logic                  done;
  logic [1:0]            status;
  logic [PAGE_BITS-1:0]  result_page;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  cfg_index_e            cfg_index   = CFG_ROOT_FRAME;
  logic [CFG_W-1:0]      cfg_data    = '0;

  five_level_page_table_walker dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start         (start),
    .busy          (busy),
    .command_i     (command),
    .virt_page_i   (virt_page),
    .phys_page_i   (phys_page),
    .unmap_i       (unmap),
    .done_o        (done),
    .status_o      (status),
    .result_page_o (result_page),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // Period of 2 ns.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Shadow of the block: the frame store, the root register and the allocator.
  // Entry layout: bit 0 valid, upper bits the page or the linked frame.
  bit   [ENTRY_W-1:0]   frame_store [DEPTH];
  logic [ROOT_W-1:0]    root_sel   = '0;
  logic [NEXT_W-1:0]    alloc_next = NEXT_W'(1);

  walk_t                expected_walks [$];
  int unsigned          items_taken = 0;
  int unsigned          cfg_taken   = 0;
  int unsigned          mismatches  = 0;
  int unsigned          idle_cycles = 0;
  int unsigned          burst_left  = 0;

  // Set by the driver for rows whose result is typed into the table.
  bit                   has_exp   = 1'b0;
  walk_t                exp_fixed = '0;

  // Walks the shadow tables for one command and applies its writes. Inner levels
  // either follow a valid link or stop (query, unmap, allocator empty) or take a
  // fresh frame, clear it and link it in. The leaf level then reads or writes.
  function automatic walk_t walk_page_table(input command_e cmd,
                                            input logic [VPN_W-1:0] vpn,
                                            input logic [PAGE_BITS-1:0] ppn,
                                            input logic rm);
    walk_t                 res;
    logic [FRAME_W-1:0]    frm;
    logic [ADDR_W-1:0]     slot;
    logic [INDEX_BITS-1:0] idx;
    bit                    halted;
    res    = '{status: STAT_OK, page: '0};
    frm    = FRAME_W'(root_sel);
    halted = 1'b0;
    for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
      if (!halted) begin
        idx  = vpn[INDEX_BITS*(LEVELS-1-lvl) +: INDEX_BITS];
        slot = {frm, idx};
        if (frame_store[slot][0]) begin
          // Only the low frame bits matter: a stray page number wraps around.
          frm = frame_store[slot][FRAME_W:1];
        end else if (cmd == CMD_QUERY) begin
          res.status = STAT_UNMAPPED;
          halted     = 1'b1;
        end else if (rm) begin
          halted = 1'b1;
        end else if (alloc_next >= NEXT_W'(FRAMES)) begin
          // Links made earlier in this walk stay in place.
          res.status = STAT_NO_FRAME;
          halted     = 1'b1;
        end else begin
          // The allocator does not care whether the frame is live.
          frm        = FRAME_W'(alloc_next);
          alloc_next = alloc_next + 1'b1;
          for (int e = 0; e < ENTRIES; e++) begin
            frame_store[{frm, INDEX_BITS'(e)}] = '0;
          end
          frame_store[slot] = {PAGE_BITS'(frm), 1'b1};
        end
      end
    end
    if (!halted) begin
      slot = {frm, vpn[INDEX_BITS-1:0]};
      if (cmd == CMD_QUERY) begin
        if (frame_store[slot][0]) begin
          res.page = frame_store[slot][ENTRY_W-1:1];
        end else begin
          res.status = STAT_UNMAPPED;
        end
      end else if (rm) begin
        frame_store[slot] = '0;
      end else begin
        frame_store[slot] = {ppn, 1'b1};
      end
    end
    return res;
  endfunction

  // Changes one slice of a virtual page, mostly to a corner value, so that walks
  // share long prefixes and keep reaching the deep levels.
  function automatic logic [VPN_W-1:0] nudge_vpn(input logic [VPN_W-1:0] base);
    logic [VPN_W-1:0]      v;
    logic [INDEX_BITS-1:0] val;
    int unsigned           lvl;
    v   = base;
    lvl = $urandom_range(0, LEVELS - 1);
    case ($urandom_range(0, 4))
      0: val = '0;
      1: val = INDEX_BITS'(1);
      2: val = '1;
      default: val = INDEX_BITS'($urandom);
    endcase
    v[INDEX_BITS*lvl +: INDEX_BITS] = val;
    return v;
  endfunction

  // Everything is sampled at the rising edge; inputs move only at the falling edge.
  always @(posedge clk) begin : monitor
    walk_t want;
    bit    moved;
    moved = 1'b0;
    // A result is matched before a new item is queued: when both happen at the
    // same edge, the result belongs to the item in flight.
    if (done) begin
      moved = 1'b1;
      if (expected_walks.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual status %0d page %h",
                 $time, status, result_page);
      end else begin
        want = expected_walks.pop_front();
        if (status !== want.status) begin
          mismatches++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, status);
        end
        if (result_page !== want.page) begin
          mismatches++;
          $display("%0t: result_page mismatch, expected %h, actual %h",
                   $time, want.page, result_page);
        end
      end
    end
    if (start && !busy) begin
      moved = 1'b1;
      // The predictor always runs so that the shadow tables stay current.
      want = walk_page_table(command, virt_page, phys_page, unmap);
      expected_walks.push_back(has_exp ? exp_fixed : want);
      items_taken++;
    end
    if (cfg_valid && cfg_ready) begin
      moved = 1'b1;
      if (cfg_index == CFG_ROOT_FRAME) begin
        root_sel = ROOT_W'(cfg_data);
      end else begin
        // A new first free frame restarts the allocator.
        alloc_next = NEXT_W'(cfg_data);
      end
      cfg_taken++;
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Presents one item and returns at the falling edge after it was taken, with
  // start still high so that a back-to-back item can follow.
  task automatic issue_item(input step_t s);
    int unsigned target;
    target    = items_taken + 1;
    has_exp   = s.has_exp;
    exp_fixed = '{status: s.status, page: s.page};
    command   <= s.cmd;
    virt_page <= s.vpn;
    phys_page <= s.ppn;
    unmap     <= s.rm;
    start     <= 1'b1;
    wait (items_taken == target);
    @(negedge clk);
  endtask

  // Sender pacing: bursts of random length, then a random gap, sometimes none.
  // With hold set, start is dropped regardless.
  task automatic pace_sender(input bit hold);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
    if (hold || gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // One register write; returns at a falling edge where nothing has been driven.
  task automatic write_reg(input cfg_index_e idx, input logic [CFG_W-1:0] val);
    int unsigned target;
    target = cfg_taken + 1;
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    wait (cfg_taken == target);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    step_t             s;
    logic [VPN_W-1:0]  known [$];
    logic [VPN_W-1:0]  base;
    logic [ROOT_W-1:0] roots [PHASES];
    logic [CFG_W-1:0]  frees [PHASES];
    int unsigned       pick;

    // Configuration per phase. The first one points the root at the leaf table of
    // page zero's path with no frames left, so leaf pages are followed as links and
    // wrap into the frame range. Then the top root with an allocator that runs dry
    // partway, an allocator starting on live frame zero, random settings and the reset settings.
    roots[0] = ROOT_W'(4);               frees[0] = CFG_W'(FRAMES);
    roots[1] = '1;                       frees[1] = CFG_W'(60);
    roots[2] = '0;                       frees[2] = '0;
    roots[3] = ROOT_W'($urandom);        frees[3] = CFG_W'($urandom_range(32, FRAMES));
    roots[4] = ROOT_W'($urandom);        frees[4] = CFG_W'(1);
    roots[5] = '0;                       frees[5] = CFG_W'(1);

    known.push_back('0);
    known.push_back(VPN_MAX);
    known.push_back(VPN_W'(1));
    known.push_back(VPN_SIDE);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The block clears its store first and holds busy meanwhile; the first
    // item simply waits for it.
    for (int i = 0; i < $size(DIRECTED_STEPS); i++) begin
      issue_item(DIRECTED_STEPS[i]);
      pace_sender(i == $size(DIRECTED_STEPS) - 1);
    end

    for (int p = 0; p < PHASES; p++) begin
      // Every result is in before the registers change.
      wait (expected_walks.size() == 0);
      @(negedge clk);
      write_reg(CFG_ROOT_FRAME, CFG_W'(roots[p]));
      write_reg(CFG_FIRST_FREE, frees[p]);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        base   = known[$urandom_range(0, known.size() - 1)];
        s      = '0;
        s.ppn  = PAGE_BITS'({$urandom, $urandom});
        s.cmd  = CMD_QUERY;
        pick   = $urandom_range(0, 99);
        if (pick < 35) begin
          // Look up a page that was mapped recently.
          s.vpn = base;
          s.rm  = 1'($urandom_range(0, 1));
        end else if (pick < 60) begin
          // Map a neighbor: reuses part of a path, extends the rest.
          s.cmd = CMD_UPDATE;
          s.vpn = nudge_vpn(base);
          known.push_back(s.vpn);
        end else if (pick < 72) begin
          s.cmd = CMD_UPDATE;
          s.rm  = 1'b1;
          s.vpn = base;
        end else if (pick < 82) begin
          // Query a neighbor, which tends to miss at some inner level.
          s.vpn = nudge_vpn(base);
        end else begin
          // Anything at all.
          s.cmd = command_e'($urandom_range(0, 1));
          s.vpn = VPN_W'({$urandom, $urandom});
          s.rm  = 1'($urandom_range(0, 1));
          if (s.cmd == CMD_UPDATE && !s.rm) begin
            known.push_back(s.vpn);
          end
        end
        if (known.size() > KNOWN_DEPTH) begin
          void'(known.pop_front());
        end
        issue_item(s);
        pace_sender(n == PHASE_ITEMS - 1);
      end
    end

    // Let the last result in, then watch a little longer for stray strobes.
    wait (expected_walks.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_walks.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
